### hw/rtl/aim_pkg.sv
// ----------------------------------------------------------------------------
// aim_pkg
// Shared types and constants of the adaptive interrupt moderation block.
// ----------------------------------------------------------------------------
package aim_pkg;

   localparam int TIME_WIDTH      = 48;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_UPDATE_PERIOD  = 3'd0,
      REG_LINK_SLOW      = 3'd1,
      REG_MIN_INTERVAL   = 3'd2,
      REG_MAX_INTERVAL   = 3'd3,
      REG_STEP_INCREMENT = 3'd4
   } csr_index_type;

   localparam logic [6:0] MIN_INTERVAL_RESET   = 7'd10;
   localparam logic [6:0] MAX_INTERVAL_RESET   = 7'd126;
   localparam logic [3:0] STEP_INCREMENT_RESET = 4'd2;

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_DECIDE    = 7'b0000010,
      ST_DIV_AVG   = 7'b0000100,
      ST_CURVE     = 7'b0001000,
      ST_DIV_ROUND = 7'b0010000,
      ST_SCALE     = 7'b0100000,
      ST_FINISH    = 7'b1000000
   } state_type;

   // Shared divider step counts
   localparam logic [5:0] AVG_STEPS   = 6'd32;
   localparam logic [5:0] ROUND_STEPS = 6'd17;
   localparam int         ROUND_PAD   = 15;

   // Packet and byte count thresholds
   localparam logic [31:0] PKT_FEW    = 32'd4;
   localparam logic [31:0] PKT_LOW    = 32'd48;
   localparam logic [31:0] PKT_MID    = 32'd96;
   localparam logic [31:0] PKT_HIGH   = 32'd256;
   localparam logic [31:0] BYTES_FEW  = 32'd9000;

   // Frame size curve
   localparam logic [31:0] AVG_KNEE0 = 32'd60;
   localparam logic [31:0] AVG_KNEE1 = 32'd316;
   localparam logic [31:0] AVG_KNEE2 = 32'd1084;
   localparam logic [31:0] AVG_KNEE3 = 32'd1968;
   localparam logic [15:0] CURVE_FLOOR = 16'd5120;
   localparam logic [15:0] CURVE_TOP   = 16'd32256;
   localparam logic [15:0] CURVE_OFS1  = 16'd2720;
   localparam logic [15:0] CURVE_OFS2  = 16'd11452;
   localparam logic [15:0] CURVE_OFS3  = 16'd22420;
   localparam logic [15:0] SLOPE1      = 16'd40;
   localparam logic [15:0] SLOPE2      = 16'd15;
   localparam logic [15:0] SLOPE3      = 16'd5;
   localparam logic [14:0] SLOW_CAP    = 15'd8064;
   localparam logic [6:0]  INTERVAL_SAT = 7'd127;

endpackage

### hw/rtl/aim_if.sv
// ----------------------------------------------------------------------------
// aim_req_if / aim_rsp_if
// Valid/ready channels carrying moderation updates and their results.
// ----------------------------------------------------------------------------
interface aim_req_if;
   logic                          valid;
   logic                          ready;
   logic [aim_pkg::TIME_WIDTH-1:0] now_time;
   logic [31:0]                   packet_count;
   logic [31:0]                   byte_count;

   modport source (output valid, output now_time, output packet_count,
                   output byte_count, input ready);
   modport sink   (input valid, input now_time, input packet_count,
                   input byte_count, output ready);
endinterface

interface aim_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] interval_value;
   logic       changed;
   logic       latency_mode;

   modport source (output valid, output interval_value, output changed,
                   output latency_mode, input ready);
   modport sink   (input valid, input interval_value, input changed,
                   input latency_mode, output ready);
endinterface

### hw/rtl/adaptive_interrupt_moderation.sv
// ----------------------------------------------------------------------------
// adaptive_interrupt_moderation
// Computes the next interrupt moderation interval from per-update traffic
// counts, using one shared restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_chan  in   valid/ready   now_time, packet_count, byte_count
//  rsp_chan  out  valid/ready   interval_value, changed, latency_mode
//  csr_*     in   csr_we        csr_index, csr_wdata (write only)
//
//  An item whose interval comes from the frame size curve passes decide, a
//  32-step divide for the average frame size, the curve state, a 17-step
//  rounded divide, scale and finish; with a zero step increment the rounded
//  divide is skipped. Other items go from decide straight to finish. The
//  divider is the only arithmetic loop.
//  req_chan is ready only while idle; a result waiting in the output
//  register does not block the next item until that item finishes.
//  Synchronous active-high reset clears the sequencer, configuration, state and
//  output valid; item, divider and output data registers are not reset.
module adaptive_interrupt_moderation (
   input  logic                                  clock,
   input  logic                                  reset,
   aim_req_if.sink                               req_chan,
   aim_rsp_if.source                             rsp_chan,
   input  logic                                  csr_we,
   input  logic [aim_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [aim_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int TW = aim_pkg::TIME_WIDTH;

   aim_pkg::state_type state_ff, state_in;

   // configuration
   logic [31:0] update_period_ff, update_period_in;
   logic        link_slow_ff, link_slow_in;
   logic [6:0]  min_interval_ff, min_interval_in;
   logic [6:0]  max_interval_ff, max_interval_in;
   logic [3:0]  step_increment_ff, step_increment_in;

   // architectural state
   logic [8:0]    current_interval_ff, current_interval_in;
   logic [7:0]    last_setting_ff, last_setting_in;
   logic [TW-1:0] deadline_ff, deadline_in;

   // item registers
   logic [TW-1:0] now_ff, now_in;
   logic [31:0]   packets_ff, packets_in;
   logic [31:0]   bytes_ff, bytes_in;
   logic          lat_ff, lat_in;
   logic [7:0]    setting_ff, setting_in;

   // shared divider
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [8:0] rsp_interval_ff, rsp_interval_in;
   logic       rsp_changed_ff, rsp_changed_in;
   logic       rsp_latency_ff, rsp_latency_in;

   // combinational helpers
   logic [32:0] div_shift;
   logic [33:0] div_diff;
   logic        div_fits;
   logic [7:0]  up_sum;
   logic [6:0]  up_val;
   logic [5:0]  half_val;
   logic [15:0] avg_low;
   logic [15:0] curve_base;
   logic [14:0] curve_val;
   logic [11:0] round_dvs;
   logic [16:0] round_dividend;
   logic [20:0] scale_prod;
   logic [6:0]  scale_val;
   logic [8:0]  new_interval;
   logic        rsp_free;

   assign req_chan.ready          = (state_ff == aim_pkg::ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.interval_value = rsp_interval_ff;
   assign rsp_chan.changed        = rsp_changed_ff;
   assign rsp_chan.latency_mode   = rsp_latency_ff;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // restoring divider step: one quotient bit per cycle
   assign div_shift = {rem_ff, quo_ff[31]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_ff};
   assign div_fits  = !div_diff[33];

   // step up, capped by max_interval
   assign up_sum = {1'b0, current_interval_ff[8:2]} + {4'b0000, step_increment_ff};
   assign up_val = (up_sum > {1'b0, max_interval_ff}) ? max_interval_ff : up_sum[6:0];
   assign half_val = current_interval_ff[8:3];

   // piecewise linear curve over the average frame size in quo_ff
   assign avg_low = {5'b00000, quo_ff[10:0]};

   always_comb begin
      logic [14:0] c;
      priority if (quo_ff <= aim_pkg::AVG_KNEE0) begin
         curve_base = aim_pkg::CURVE_FLOOR;
      end else if (quo_ff <= aim_pkg::AVG_KNEE1) begin
         curve_base = avg_low * aim_pkg::SLOPE1 + aim_pkg::CURVE_OFS1;
      end else if (quo_ff <= aim_pkg::AVG_KNEE2) begin
         curve_base = avg_low * aim_pkg::SLOPE2 + aim_pkg::CURVE_OFS2;
      end else if (quo_ff < aim_pkg::AVG_KNEE3) begin
         curve_base = avg_low * aim_pkg::SLOPE3 + aim_pkg::CURVE_OFS3;
      end else begin
         curve_base = aim_pkg::CURVE_TOP;
      end
      c = lat_ff ? {1'b0, curve_base[14:1]} : curve_base[14:0];
      if (link_slow_ff && c > aim_pkg::SLOW_CAP) begin
         c = aim_pkg::SLOW_CAP;
      end
      curve_val = c;
   end

   assign round_dvs = link_slow_ff ? {2'b00, step_increment_ff, 6'b000000}
                                   : {step_increment_ff, 8'b00000000};
   // ceiling divide: add divisor minus one
   assign round_dividend = {2'b00, curve_val} + {5'b00000, round_dvs} - 17'd1;

   assign scale_prod = quo_ff[16:0] * step_increment_ff;
   assign scale_val  = (scale_prod > {14'd0, aim_pkg::INTERVAL_SAT})
                       ? aim_pkg::INTERVAL_SAT : scale_prod[6:0];

   assign new_interval = {setting_ff[6:0], 2'b00};

   // configuration writes
   always_comb begin
      update_period_in  = update_period_ff;
      link_slow_in      = link_slow_ff;
      min_interval_in   = min_interval_ff;
      max_interval_in   = max_interval_ff;
      step_increment_in = step_increment_ff;
      if (csr_we) begin
         case (csr_index)
            aim_pkg::REG_UPDATE_PERIOD:  update_period_in  = csr_wdata;
            aim_pkg::REG_LINK_SLOW:      link_slow_in      = csr_wdata[0];
            aim_pkg::REG_MIN_INTERVAL:   min_interval_in   = csr_wdata[6:0];
            aim_pkg::REG_MAX_INTERVAL:   max_interval_in   = csr_wdata[6:0];
            aim_pkg::REG_STEP_INCREMENT: step_increment_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in            = state_ff;
      current_interval_in = current_interval_ff;
      last_setting_in     = last_setting_ff;
      deadline_in         = deadline_ff;
      now_in              = now_ff;
      packets_in          = packets_ff;
      bytes_in            = bytes_ff;
      lat_in              = lat_ff;
      setting_in          = setting_ff;
      quo_in              = quo_ff;
      rem_in              = rem_ff;
      dvs_in              = dvs_ff;
      cnt_in              = cnt_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_chan.ready;
      rsp_interval_in     = rsp_interval_ff;
      rsp_changed_in      = rsp_changed_ff;
      rsp_latency_in      = rsp_latency_ff;

      unique case (state_ff)
         aim_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               now_in     = req_chan.now_time;
               packets_in = req_chan.packet_count;
               bytes_in   = req_chan.byte_count;
               state_in   = aim_pkg::ST_DECIDE;
            end
         end
         aim_pkg::ST_DECIDE: begin
            deadline_in = now_ff + TW'(update_period_ff);
            state_in    = aim_pkg::ST_FINISH;
            // curve paths load the divider with bytes / packets
            quo_in = bytes_ff;
            rem_in = '0;
            dvs_in = packets_ff;
            cnt_in = aim_pkg::AVG_STEPS;
            priority if (now_ff > deadline_ff) begin
               setting_in = {1'b1, min_interval_ff};
            end else if (packets_ff == '0) begin
               setting_in = {last_setting_ff[7], up_val};
            end else if (packets_ff < aim_pkg::PKT_FEW && bytes_ff < aim_pkg::BYTES_FEW) begin
               lat_in   = 1'b1;
               state_in = aim_pkg::ST_DIV_AVG;
            end else if (packets_ff < aim_pkg::PKT_LOW) begin
               setting_in = {1'b0, up_val};
            end else if (packets_ff < aim_pkg::PKT_MID) begin
               setting_in = {1'b0, current_interval_ff[8:2]};
            end else if (packets_ff < aim_pkg::PKT_HIGH) begin
               setting_in = ({1'b0, half_val} < min_interval_ff)
                            ? {1'b0, min_interval_ff} : {2'b00, half_val};
            end else begin
               lat_in   = 1'b0;
               state_in = aim_pkg::ST_DIV_AVG;
            end
         end
         aim_pkg::ST_DIV_AVG, aim_pkg::ST_DIV_ROUND: begin
            quo_in = {quo_ff[30:0], div_fits};
            rem_in = div_fits ? div_diff[31:0] : div_shift[31:0];
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = (state_ff == aim_pkg::ST_DIV_AVG) ? aim_pkg::ST_CURVE
                                                            : aim_pkg::ST_SCALE;
            end
         end
         aim_pkg::ST_CURVE: begin
            if (step_increment_ff == 4'd0) begin
               setting_in = {lat_ff, 7'd0};
               state_in   = aim_pkg::ST_FINISH;
            end else begin
               // dividend sits in the top bits so only its width is iterated
               quo_in   = {round_dividend, {aim_pkg::ROUND_PAD{1'b0}}};
               rem_in   = '0;
               dvs_in   = {20'd0, round_dvs};
               cnt_in   = aim_pkg::ROUND_STEPS;
               state_in = aim_pkg::ST_DIV_ROUND;
            end
         end
         aim_pkg::ST_SCALE: begin
            setting_in = {lat_ff, scale_val};
            state_in   = aim_pkg::ST_FINISH;
         end
         aim_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_interval_in     = new_interval;
               rsp_changed_in      = (new_interval != current_interval_ff);
               rsp_latency_in      = setting_ff[7];
               current_interval_in = new_interval;
               last_setting_in     = setting_ff;
               state_in            = aim_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aim_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= aim_pkg::ST_IDLE;
         update_period_ff    <= '0;
         link_slow_ff        <= 1'b0;
         min_interval_ff     <= aim_pkg::MIN_INTERVAL_RESET;
         max_interval_ff     <= aim_pkg::MAX_INTERVAL_RESET;
         step_increment_ff   <= aim_pkg::STEP_INCREMENT_RESET;
         current_interval_ff <= '0;
         last_setting_ff     <= '0;
         deadline_ff         <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         update_period_ff    <= update_period_in;
         link_slow_ff        <= link_slow_in;
         min_interval_ff     <= min_interval_in;
         max_interval_ff     <= max_interval_in;
         step_increment_ff   <= step_increment_in;
         current_interval_ff <= current_interval_in;
         last_setting_ff     <= last_setting_in;
         deadline_ff         <= deadline_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      packets_ff      <= packets_in;
      bytes_ff        <= bytes_in;
      lat_ff          <= lat_in;
      setting_ff      <= setting_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      dvs_ff          <= dvs_in;
      cnt_ff          <= cnt_in;
      rsp_interval_ff <= rsp_interval_in;
      rsp_changed_ff  <= rsp_changed_in;
      rsp_latency_ff  <= rsp_latency_in;
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adaptive_interrupt_moderation. A queue of updates
// feeds a valid/ready driver; a monitor predicts each interval setting on
// accept and checks the results in order, across many register settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int N_PHASES        = 12;
   localparam int ITEMS_PER_PHASE = 86;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 60;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [aim_pkg::TIME_WIDTH-1:0] now_time;
      logic [31:0]                    packet_count;
      logic [31:0]                    byte_count;
   } update_type;

   typedef struct packed {
      logic [8:0] interval_value;
      logic       changed;
      logic       latency_mode;
   } interval_result_type;

   typedef struct packed {
      logic [31:0] period;
      logic        slow;
      logic [6:0]  min_ivl;
      logic [6:0]  max_ivl;
      logic [3:0]  step;
   } settings_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [aim_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [aim_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   aim_req_if req_chan ();
   aim_rsp_if rsp_chan ();

   adaptive_interrupt_moderation u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of registers and state
   settings_type                   cfg;
   logic [8:0]                     current_interval;
   logic [7:0]                     last_setting;
   logic [aim_pkg::TIME_WIDTH-1:0] deadline;
   // deadline as the stimulus side sees it, advanced as items are queued
   logic [aim_pkg::TIME_WIDTH-1:0] gen_deadline;

   update_type          pending_updates[$];
   interval_result_type predicted_results[$];

   logic        req_taken;
   logic        send_idle_on, recv_idle_on;
   logic        hold_off_pending;
   int unsigned send_gap, recv_gap, hold_off_left;
   int unsigned quiet_cycles;
   int unsigned fail_count, update_count, result_count;
   int unsigned late_count, curve_count, settings_count;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   function automatic logic [6:0] stepped_interval();
      logic [7:0] v;
      v = {1'b0, current_interval[8:2]} + {4'b0, cfg.step};
      return (v > {1'b0, cfg.max_ivl}) ? cfg.max_ivl : v[6:0];
   endfunction

   function automatic logic [6:0] frame_size_interval(logic [31:0] bytes, logic [31:0] pkts,
                                                      logic halve);
      logic [31:0] avg, divisor, n;
      avg = bytes / pkts;
      if (avg <= 60) avg = 5120;
      else if (avg <= 316) avg = avg * 40 + 2720;
      else if (avg <= 1084) avg = avg * 15 + 11452;
      else if (avg < 1968) avg = avg * 5 + 22420;
      else avg = 32256;
      if (halve) avg = avg >> 1;
      if (cfg.step == 4'd0) return 7'd0;
      if (cfg.slow) begin
         if (avg > 8064) avg = 8064;
         divisor = {22'b0, cfg.step, 6'b0};
      end else begin
         divisor = {20'b0, cfg.step, 8'b0};
      end
      n = ((avg + divisor - 1) / divisor) * cfg.step;
      return (n > 127) ? 7'd127 : n[6:0];
   endfunction

   function automatic interval_result_type moderate_update(
         logic [aim_pkg::TIME_WIDTH-1:0] now, logic [31:0] pkts, logic [31:0] bytes);
      logic [7:0]          setting;
      logic [6:0]          halved;
      logic [8:0]          value;
      interval_result_type r;
      if (now > deadline) begin
         setting = {1'b1, cfg.min_ivl};
         late_count++;
      end else if (pkts == 0) begin
         setting = {last_setting[7], stepped_interval()};
      end else if (pkts < 4 && bytes < 9000) begin
         setting = {1'b1, frame_size_interval(bytes, pkts, 1'b1)};
         curve_count++;
      end else if (pkts < 48) begin
         setting = {1'b0, stepped_interval()};
      end else if (pkts < 96) begin
         setting = {1'b0, current_interval[8:2]};
      end else if (pkts < 256) begin
         halved = {1'b0, current_interval[8:3]};
         setting = {1'b0, (halved < cfg.min_ivl) ? cfg.min_ivl : halved};
      end else begin
         setting = {1'b0, frame_size_interval(bytes, pkts, 1'b0)};
         curve_count++;
      end
      last_setting = setting;
      deadline = now + aim_pkg::TIME_WIDTH'(cfg.period);
      value = {setting[6:0], 2'b00};
      r.interval_value = value;
      r.changed = (value != current_interval);
      r.latency_mode = setting[7];
      current_interval = value;
      return r;
   endfunction

   function automatic settings_type make_settings(logic [31:0] period, logic slow,
                                                  logic [6:0] min_ivl, logic [6:0] max_ivl,
                                                  logic [3:0] step);
      settings_type s;
      s.period = period;
      s.slow = slow;
      s.min_ivl = min_ivl;
      s.max_ivl = max_ivl;
      s.step = step;
      return s;
   endfunction

   function automatic settings_type random_settings();
      logic [31:0] period;
      logic [3:0]  step;
      case ($urandom_range(0, 2))
         0: period = 32'd0;
         1: period = $urandom_range(1, 5000);
         default: period = $urandom;
      endcase
      step = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      return make_settings(period, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                           7'($urandom_range(0, 127)), step);
   endfunction

   // one write per cycle, enable held high across the burst
   task automatic apply_settings(settings_type s);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= aim_pkg::REG_UPDATE_PERIOD;
      csr_wdata <= s.period;
      @(negedge clock);
      csr_index <= aim_pkg::REG_LINK_SLOW;
      csr_wdata <= {31'b0, s.slow};
      @(negedge clock);
      csr_index <= aim_pkg::REG_MIN_INTERVAL;
      csr_wdata <= {25'b0, s.min_ivl};
      @(negedge clock);
      csr_index <= aim_pkg::REG_MAX_INTERVAL;
      csr_wdata <= {25'b0, s.max_ivl};
      @(negedge clock);
      csr_index <= aim_pkg::REG_STEP_INCREMENT;
      csr_wdata <= {28'b0, s.step};
      @(negedge clock);
      csr_we <= 1'b0;
      cfg = s;
      settings_count++;
   endtask

   task automatic queue_update(logic [aim_pkg::TIME_WIDTH-1:0] now, logic [31:0] pkts,
                               logic [31:0] bytes);
      update_type u;
      u.now_time = now;
      u.packet_count = pkts;
      u.byte_count = bytes;
      pending_updates.push_back(u);
      gen_deadline = now + aim_pkg::TIME_WIDTH'(cfg.period);
   endtask

   task automatic queue_directed(int unsigned set);
      case (set)
         0: begin
            queue_update(gen_deadline, 32'd0, 32'd0);            // equal time is on time
            queue_update(gen_deadline + 1, 32'd0, 32'd0);        // one tick late
            queue_update(gen_deadline, 32'd0, 32'hFFFF_FFFF);    // keeps latency flag
            queue_update(gen_deadline, 32'd1, 32'd60);
            queue_update(gen_deadline, 32'd1, 32'd61);
            queue_update(gen_deadline, 32'd3, 32'd8999);
            queue_update(gen_deadline, 32'd3, 32'd9000);
            queue_update(gen_deadline, 32'd4, 32'd0);
            queue_update(gen_deadline, 32'd47, 32'd1000);
            queue_update(gen_deadline, 32'd48, 32'd1000);
            queue_update(gen_deadline, 32'd95, 32'd1000);
            queue_update(gen_deadline, 32'd96, 32'd1000);
            queue_update(gen_deadline, 32'd255, 32'd1000);
            queue_update(gen_deadline, 32'd256, 32'd256 * 32'd1968);
            queue_update(gen_deadline, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            queue_update({aim_pkg::TIME_WIDTH{1'b1}}, 32'd0, 32'd0);
         end
         1: begin
            // top of curve at a large step overflows, and bounds are inverted
            queue_update(gen_deadline, 32'd300, 32'd300 * 32'd3000);
            queue_update(gen_deadline, 32'd1, 32'd1084);
            queue_update(gen_deadline, 32'd10, 32'd500);
            queue_update(gen_deadline, 32'd200, 32'd500);
         end
         default: begin
            // zero step: curve gives nothing, step-up adds nothing
            queue_update(gen_deadline, 32'd1, 32'd500);
            queue_update(gen_deadline, 32'd500, 32'd500 * 32'd2000);
            queue_update(gen_deadline, 32'd0, 32'd0);
         end
      endcase
   endtask

   task automatic queue_random_update();
      logic [aim_pkg::TIME_WIDTH-1:0] now;
      logic [31:0]                    pkts, bytes, frame;
      int unsigned                    sel, back;
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
         back = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5000);
         if (back > gen_deadline) back = 32'(gen_deadline);
         now = gen_deadline - back;
      end else if (sel < 90) begin
         now = gen_deadline + aim_pkg::TIME_WIDTH'($urandom_range(1, 3));
      end else begin
         now = aim_pkg::TIME_WIDTH'({$urandom, $urandom});
      end
      frame = $urandom_range(0, 2500);
      case ($urandom_range(0, 9))
         0: begin pkts = 32'd0; bytes = $urandom; end
         1, 2: begin pkts = $urandom_range(1, 3); bytes = $urandom_range(0, 8999); end
         3: begin pkts = $urandom_range(1, 3); bytes = $urandom_range(9000, 200000); end
         4: begin pkts = $urandom_range(4, 47); bytes = $urandom; end
         5: begin pkts = $urandom_range(48, 95); bytes = $urandom; end
         6: begin pkts = $urandom_range(96, 255); bytes = $urandom; end
         7, 8: begin
            pkts = $urandom_range(256, 4096);
            bytes = pkts * frame + $urandom_range(0, pkts - 1);
         end
         default: begin pkts = $urandom; bytes = $urandom; end
      endcase
      queue_update(now, pkts, bytes);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_updates.size() != 0 || req_chan.valid ||
             predicted_results.size() != 0 || !req_chan.ready);
   endtask

   // sender
   always @(negedge clock) begin : drive_p
      update_type nxt;
      logic       offer;
      offer = req_chan.valid;
      if (!reset) begin
         if (offer && req_taken) offer = 1'b0;
         if (!offer) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_updates.size() != 0) begin
               nxt = pending_updates.pop_front();
               req_chan.now_time     <= nxt.now_time;
               req_chan.packet_count <= nxt.packet_count;
               req_chan.byte_count   <= nxt.byte_count;
               offer = 1'b1;
               send_gap = send_idle_on ? pick_gap() : 0;
            end
         end
      end
      req_chan.valid <= offer;
   end

   // receiver, with the long hold-off counted here
   always @(negedge clock) begin : receive_p
      logic take;
      take = 1'b0;
      if (hold_off_left != 0) begin
         hold_off_left--;
      end else if (hold_off_pending) begin
         hold_off_left = HOLD_OFF_CYCLES;
         hold_off_pending = 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
      end else begin
         take = 1'b1;
         if (recv_idle_on && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
      end
      rsp_chan.ready <= take && !reset;
   end

   always @(posedge clock) begin : observe_p
      interval_result_type seen, want;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predicted_results.push_back(moderate_update(req_chan.now_time,
                                                        req_chan.packet_count,
                                                        req_chan.byte_count));
            update_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.interval_value = rsp_chan.interval_value;
            seen.changed = rsp_chan.changed;
            seen.latency_mode = rsp_chan.latency_mode;
            result_count++;
            if (predicted_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("result %0d arrived with nothing outstanding: interval %0d",
                           result_count, seen.interval_value);
            end else begin
               want = predicted_results.pop_front();
               if (seen.interval_value !== want.interval_value ||
                   seen.changed !== want.changed ||
                   seen.latency_mode !== want.latency_mode) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("result %0d: interval %0d/%0d changed %0b/%0b latency %0b/%0b %s",
                              result_count, want.interval_value, seen.interval_value,
                              want.changed, seen.changed, want.latency_mode,
                              seen.latency_mode, "(expected/actual)");
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog_p
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus_p
      settings_type s;
      int unsigned  phase;
      req_chan.valid        = 1'b0;
      req_chan.now_time     = '0;
      req_chan.packet_count = '0;
      req_chan.byte_count   = '0;
      rsp_chan.ready        = 1'b0;
      csr_we    = 1'b0;
      csr_index = aim_pkg::REG_UPDATE_PERIOD;
      csr_wdata = '0;
      req_taken = 1'b0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      hold_off_pending = 1'b0;
      send_gap = 0;
      recv_gap = 0;
      hold_off_left = 0;
      quiet_cycles = 0;
      fail_count = 0;
      update_count = 0;
      result_count = 0;
      late_count = 0;
      curve_count = 0;
      settings_count = 0;
      cfg = make_settings(32'd0, 1'b0, aim_pkg::MIN_INTERVAL_RESET,
                          aim_pkg::MAX_INTERVAL_RESET, aim_pkg::STEP_INCREMENT_RESET);
      current_interval = '0;
      last_setting = '0;
      deadline = '0;
      gen_deadline = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0: s = make_settings(32'd1000, 1'b0, 7'd10, 7'd126, 4'd2);
            1: s = make_settings(32'hFFFF_FFFF, 1'b0, 7'd100, 7'd20, 4'd8);
            2: s = make_settings(32'd0, 1'b1, 7'd0, 7'd127, 4'd0);
            3: s = make_settings(32'd5000, 1'b1, 7'd127, 7'd127, 4'd15);
            4: s = make_settings(32'd2000, 1'b0, 7'd0, 7'd0, 4'd1);
            default: s = random_settings();
         endcase
         // phase 5 runs flat out; phase 6 backs up the block behind a long hold-off
         send_idle_on = (phase != 5 && phase != 6);
         recv_idle_on = (phase != 5);
         apply_settings(s);
         if (phase == 6) @(posedge clock) hold_off_pending = 1'b1;
         if (phase < 3) queue_directed(phase);
         repeat (ITEMS_PER_PHASE) queue_random_update();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d updates under %0d register settings, %0d results checked.",
               update_count, settings_count, result_count);
      $display("Deadline fallbacks: %0d, frame size curve settings: %0d.",
               late_count, curve_count);
      if (fail_count == 0 && predicted_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
